[rtl/core/sync_length_xor_deframer_assert.svh]
// Assertion macros for the deframer RTL.
`ifndef SYNC_LENGTH_XOR_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define SLD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/sld_pkg.sv]
`default_nettype none

package sld_pkg;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_FRAME_BYTES = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd3;

	localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [8:0] MAX_FRAME_BYTES_RST = 9'd256;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

	// Two sync bytes, type, length and checksum around the payload.
	localparam logic [9:0] FRAME_OVERHEAD = 10'd5;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		ST_GOOD = 3'd0,
		ST_BAD_SYNC = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_CSUM_BAD = 3'd3,
		ST_TIMEOUT = 3'd4
	} stat_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_TYPE = 3'd2,
		PH_LEN = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [8:0] max_frame_bytes;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic out_kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_kind;
		logic [7:0] frame_len;
		stat_t frame_status;
		logic [7:0] error_run;
		logic link_ok;
		logic last_payload;
	} res_t;

endpackage

`default_nettype wire

[rtl/core/sld_cfg.sv]
`default_nettype none

module sld_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sld_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [sld_pkg::CfgDataW-1:0] cfg_data,
	output sld_pkg::cfg_t cfg
);
	import sld_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.max_frame_bytes <= MAX_FRAME_BYTES_RST;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST: cfg_q.sync_first <= cfg_data[7:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[7:0];
				REG_MAX_FRAME_BYTES: cfg_q.max_frame_bytes <= cfg_data[8:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[15:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/sld_engine.sv]
`default_nettype none

module sld_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire sld_pkg::cfg_t cfg,
	input wire logic step,
	input wire logic req_type,
	input wire logic [7:0] rx_byte,
	output logic res_valid,
	output sld_pkg::res_t res
);
	import sld_pkg::*;

	phase_t phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] kind_q, kind_d;
	logic [7:0] len_q, len_d;
	logic [7:0] pos_q, pos_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0] fail_q, fail_d;
	logic link_q, link_d;

	logic [16:0] tick_next;
	logic [8:0] pos_next;
	logic too_long;
	logic is_last;
	logic report;
	stat_t status;

	assign tick_next = {1'b0, tick_q} + 17'd1;
	assign pos_next = {1'b0, pos_q} + 9'd1;
	assign too_long = ({2'b00, rx_byte} + FRAME_OVERHEAD) > {1'b0, cfg.max_frame_bytes};
	assign is_last = pos_next >= {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q <= '0;
			kind_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			tick_q <= '0;
			fail_q <= '0;
			link_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			xor_q <= xor_d;
			kind_q <= kind_d;
			len_q <= len_d;
			pos_q <= pos_d;
			tick_q <= tick_d;
			fail_q <= fail_d;
			link_q <= link_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		xor_d = xor_q;
		kind_d = kind_q;
		len_d = len_q;
		pos_d = pos_q;
		tick_d = tick_q;
		fail_d = fail_q;
		link_d = link_q;
		res_valid = 1'b0;
		report = 1'b0;
		status = ST_GOOD;
		res = '0;
		if (step) begin
			if (req_type == REQ_TICK) begin
				if (phase_q != PH_HUNT) begin
					if (tick_next > {1'b0, cfg.timeout_ticks}) begin
						report = 1'b1;
						status = ST_TIMEOUT;
					end else begin
						tick_d = tick_next[15:0];
					end
				end
			end else begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == cfg.sync_first) begin
							phase_d = PH_SYNC2;
							tick_d = '0;
							kind_d = '0;
							len_d = '0;
							xor_d = '0;
							pos_d = '0;
						end
					end
					PH_SYNC2: begin
						if (rx_byte != cfg.sync_second) begin
							report = 1'b1;
							status = ST_BAD_SYNC;
						end else begin
							phase_d = PH_TYPE;
						end
					end
					PH_TYPE: begin
						kind_d = rx_byte;
						xor_d = rx_byte;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						len_d = rx_byte;
						xor_d = xor_q ^ rx_byte;
						pos_d = '0;
						if (too_long) begin
							report = 1'b1;
							status = ST_TOO_LONG;
						end else if (rx_byte == 8'd0) begin
							phase_d = PH_CSUM;
						end else begin
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						xor_d = xor_q ^ rx_byte;
						pos_d = pos_next[7:0];
						res_valid = 1'b1;
						res.out_kind = KIND_PAYLOAD;
						res.payload_byte = rx_byte;
						res.payload_index = pos_q;
						res.last_payload = is_last;
						if (is_last) begin
							phase_d = PH_CSUM;
						end
					end
					PH_CSUM: begin
						report = 1'b1;
						if (rx_byte == xor_q) begin
							link_d = 1'b1;
							fail_d = '0;
							status = ST_GOOD;
						end else begin
							if (fail_q != 8'hFF) begin
								fail_d = fail_q + 8'd1;
							end
							status = ST_CSUM_BAD;
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
		if (report) begin
			phase_d = PH_HUNT;
			res_valid = 1'b1;
			res.out_kind = KIND_REPORT;
			res.frame_status = status;
		end
		// Reports see the length just taken and the updated error count.
		res.frame_kind = kind_d;
		res.frame_len = len_d;
		res.error_run = fail_d;
		res.link_ok = link_d;
	end

endmodule

`default_nettype wire

[rtl/core/sync_length_xor_deframer.sv]
// Frame deframer for a byte stream with two sync bytes, type, length, payload and an
// XOR checksum. Each input word is a received byte or a time tick; each yields at most
// one output word, a payload byte with its index or an end-of-frame report. The block
// takes one input word every clock cycle unless the output stalls; each word waits in the input
// register, and as it moves on the frame state is updated and its result is written to the
// result register. Write the configuration registers only while no word is in flight; the
// defaults are sync bytes 0xAA and 0x55, 256-byte frames, 100 ticks.
`default_nettype none
`include "sync_length_xor_deframer_assert.svh"

module sync_length_xor_deframer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic req_type,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic out_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [7:0] frame_kind,
	output logic [7:0] frame_len,
	output logic [2:0] frame_status,
	output logic [7:0] error_run,
	output logic link_ok,
	output logic last_payload,
	input wire logic cfg_we,
	input wire logic [sld_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [sld_pkg::CfgDataW-1:0] cfg_data
);
	import sld_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	logic req_type_s1;
	logic [7:0] rx_byte_s1;
	logic advance;
	logic res_valid;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	sld_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// The word in the input register moves on when the result register is free or drains.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			rx_byte_s1 <= rx_byte;
		end
	end

	sld_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(advance),
		.req_type(req_type_s1),
		.rx_byte(rx_byte_s1),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = out_q.out_kind;
	assign payload_byte = out_q.payload_byte;
	assign payload_index = out_q.payload_index;
	assign frame_kind = out_q.frame_kind;
	assign frame_len = out_q.frame_len;
	assign frame_status = out_q.frame_status;
	assign error_run = out_q.error_run;
	assign link_ok = out_q.link_ok;
	assign last_payload = out_q.last_payload;

	`SLD_ASSERT(a_stall_blocks_input, clk, arst_n, (valid_s1 && out_valid_q && !out_ready) |-> !in_ready, "input taken while both registers are full")
	`SLD_ASSERT(a_report_clean, clk, arst_n, (out_valid && out_kind == KIND_REPORT) |-> (payload_byte == 8'd0 && payload_index == 8'd0 && !last_payload), "report word carries payload fields")
	`SLD_ASSERT(a_payload_status, clk, arst_n, (out_valid && out_kind == KIND_PAYLOAD) |-> (frame_status == ST_GOOD), "payload word carries a status")
	`SLD_ASSERT(a_good_frame_link, clk, arst_n, (out_valid && out_kind == KIND_REPORT && frame_status == ST_GOOD) |-> (link_ok && error_run == 8'd0), "good frame without link or with errors")
	`SLD_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> (!out_valid && !valid_s1), "words held during reset")

endmodule

`default_nettype wire
